FILE: hdl/rldfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED drive and fault monitor package
// Shared types, codes and constants for the drive and fault monitor block.
// ----------------------------------------------------------------------------
package rldfm_pkg;

    localparam int DUTY_PERIOD = 32000;
    localparam int ADC_BITS    = 12;

    localparam int DUTY_W = 15;
    localparam int TRIG_W = 14;
    localparam int REQ_W  = 16;
    localparam int COMP_W = 12;
    localparam int MV_W   = 13;
    localparam int DEB_W  = 8;
    localparam int NCHAN  = 3;

    localparam logic [DUTY_W-1:0] DUTY_MAX    = DUTY_W'(DUTY_PERIOD - 1);
    localparam logic [REQ_W-1:0]  CAL_FORCED  = REQ_W'((DUTY_PERIOD / 10) * 4);

    // mv = adc * 1000 / 560 compared against limits: scale both sides instead
    localparam int MV_NUM  = 1000;
    localparam int MV_DEN  = 560;
    localparam int MV_GCD  = 40;
    localparam int MV_MUL  = MV_NUM / MV_GCD;
    localparam int MV_DIV  = MV_DEN / MV_GCD;
    localparam int SCALE_W = 18;

    localparam logic [MV_W-1:0]   OPEN_LIMIT_RST  = MV_W'(6999);
    localparam logic [MV_W-1:0]   SHORT_LIMIT_RST = MV_W'(400);
    localparam logic [DEB_W-1:0]  DEBOUNCE_RST    = DEB_W'(100);
    localparam logic [DUTY_W-1:0] SETTLE_RST      = DUTY_W'(480);

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        OP_SET_DUTY = 2'd0,
        OP_SAMPLE   = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_SLEEP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_INIT   = 2'd0,
        ST_NORMAL = 2'd1,
        ST_OPEN   = 2'd2,
        ST_SHORT  = 2'd3
    } chan_status_t;

    typedef enum logic [2:0] {
        REG_CAL_MODE    = 3'd0,
        REG_RED_COMP    = 3'd1,
        REG_GREEN_COMP  = 3'd2,
        REG_BLUE_COMP   = 3'd3,
        REG_OPEN_LIMIT  = 3'd4,
        REG_SHORT_LIMIT = 3'd5,
        REG_DEBOUNCE    = 3'd6,
        REG_SETTLE      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [REQ_W-1:0]    req_red;
        logic [REQ_W-1:0]    req_green;
        logic [REQ_W-1:0]    req_blue;
        logic [ADC_BITS-1:0] adc_red;
        logic [ADC_BITS-1:0] adc_green;
        logic [ADC_BITS-1:0] adc_blue;
    } cmd_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_red;
        logic [DUTY_W-1:0] duty_green;
        logic [DUTY_W-1:0] duty_blue;
        logic [TRIG_W-1:0] trig_red;
        logic [TRIG_W-1:0] trig_green;
        logic [TRIG_W-1:0] trig_blue;
        logic [1:0]        red_state;
        logic [1:0]        green_state;
        logic [1:0]        blue_state;
        logic              led_fault;
    } res_t;

    function automatic logic is_fault(input chan_status_t s);
        return (s == ST_OPEN) || (s == ST_SHORT);
    endfunction

endpackage

FILE: hdl/rldfm_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one command item per transfer.
// ----------------------------------------------------------------------------
interface rldfm_cmd_if
    import rldfm_pkg::*;
;
    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/rldfm_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface rldfm_res_if
    import rldfm_pkg::*;
;
    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/rgb_led_drive_fault_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED drive and fault monitor
// Three-channel PWM duty store with ADC trigger delay and debounced fault
// classification of LED voltages.
// ----------------------------------------------------------------------------
// Usage:
//   cmd    : valid/ready input, one command (opcode, requests, ADC samples)
//            per transfer.
//   result : valid/ready output, one result per command showing duties,
//            trigger delays and channel statuses after that command.
//   APB    : eight 32-bit registers at byte address 4*index. The user must
//            write them only while the block is idle; the block does not check.
// pready is tied high. Result valid rises after the command passes the
// input register, then the state update and result register. Throughput is
// one command per cycle while result is not stalled; the state registers are
// updated in the same edge that loads the result register.
// Reset clears duties, enables and statuses, reloads the debounce counters
// with 100 and restores register defaults. When result stalls, the result
// register holds and one more command is buffered in the input register
// before cmd.ready drops.
// ----------------------------------------------------------------------------
module rgb_led_drive_fault_monitor
    import rldfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    rldfm_cmd_if.sink         cmd,
    rldfm_res_if.source       result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // configuration registers
    logic [1:0]        cal_mode_reg;
    logic [COMP_W-1:0] comp_reg [NCHAN];
    logic [MV_W-1:0]   open_limit_reg;
    logic [MV_W-1:0]   short_limit_reg;
    logic [DEB_W-1:0]  debounce_reg;
    logic [DUTY_W-1:0] settle_reg;

    logic     apb_wr;
    reg_idx_t apb_idx;

    // pipeline
    logic         cmd_valid_reg;
    cmd_t         cmd_data_reg;
    logic         res_valid_reg;
    res_t         res_data_reg;
    res_t         res_data_next;
    logic         advance;
    logic         take;

    // channel state
    logic [DUTY_W-1:0] duty_reg      [NCHAN];
    logic [DUTY_W-1:0] duty_next     [NCHAN];
    logic              en_reg        [NCHAN];
    logic              en_next       [NCHAN];
    chan_status_t      status_reg    [NCHAN];
    chan_status_t      status_next   [NCHAN];
    logic [DEB_W-1:0]  deb_reg       [NCHAN];
    logic [DEB_W-1:0]  deb_next      [NCHAN];

    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite;
    assign apb_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_mode_reg    <= 2'd0;
            comp_reg[0]     <= '0;
            comp_reg[1]     <= '0;
            comp_reg[2]     <= '0;
            open_limit_reg  <= OPEN_LIMIT_RST;
            short_limit_reg <= SHORT_LIMIT_RST;
            debounce_reg    <= DEBOUNCE_RST;
            settle_reg      <= SETTLE_RST;
        end
        else if (apb_wr)
        begin
            unique case (apb_idx)
                REG_CAL_MODE:    cal_mode_reg    <= pwdata[1:0];
                REG_RED_COMP:    comp_reg[0]     <= pwdata[COMP_W-1:0];
                REG_GREEN_COMP:  comp_reg[1]     <= pwdata[COMP_W-1:0];
                REG_BLUE_COMP:   comp_reg[2]     <= pwdata[COMP_W-1:0];
                REG_OPEN_LIMIT:  open_limit_reg  <= pwdata[MV_W-1:0];
                REG_SHORT_LIMIT: short_limit_reg <= pwdata[MV_W-1:0];
                REG_DEBOUNCE:    debounce_reg    <= pwdata[DEB_W-1:0];
                REG_SETTLE:      settle_reg      <= pwdata[DUTY_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (apb_idx)
            REG_CAL_MODE:    prdata = APB_DW'(cal_mode_reg);
            REG_RED_COMP:    prdata = APB_DW'(comp_reg[0]);
            REG_GREEN_COMP:  prdata = APB_DW'(comp_reg[1]);
            REG_BLUE_COMP:   prdata = APB_DW'(comp_reg[2]);
            REG_OPEN_LIMIT:  prdata = APB_DW'(open_limit_reg);
            REG_SHORT_LIMIT: prdata = APB_DW'(short_limit_reg);
            REG_DEBOUNCE:    prdata = APB_DW'(debounce_reg);
            REG_SETTLE:      prdata = APB_DW'(settle_reg);
        endcase
    end

    // handshake
    assign advance      = !res_valid_reg || result.ready;
    assign take         = cmd_valid_reg && advance;
    assign cmd.ready    = !cmd_valid_reg || advance;
    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                cmd_valid_reg <= cmd.valid;
            end
            if (take)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            cmd_data_reg <= cmd.data;
        end
        if (take)
        begin
            res_data_reg <= res_data_next;
        end
    end

    // state update
    always_comb
    begin
        logic [REQ_W-1:0]    req      [NCHAN];
        logic [ADC_BITS-1:0] adc      [NCHAN];
        logic [REQ_W:0]      sum;
        logic [SCALE_W-1:0]  scaled;
        logic [SCALE_W-1:0]  open_thr;
        logic [SCALE_W-1:0]  short_thr;
        chan_status_t        cls;
        opcode_t             op;

        op        = opcode_t'(cmd_data_reg.opcode);
        req[0]    = cmd_data_reg.req_red;
        req[1]    = cmd_data_reg.req_green;
        req[2]    = cmd_data_reg.req_blue;
        adc[0]    = cmd_data_reg.adc_red;
        adc[1]    = cmd_data_reg.adc_green;
        adc[2]    = cmd_data_reg.adc_blue;
        open_thr  = SCALE_W'(open_limit_reg) * SCALE_W'(MV_DIV);
        short_thr = SCALE_W'(short_limit_reg) * SCALE_W'(MV_DIV);

        for (int i = 0; i < NCHAN; i++)
        begin
            duty_next[i]   = duty_reg[i];
            en_next[i]     = en_reg[i];
            status_next[i] = status_reg[i];
            deb_next[i]    = deb_reg[i];

            if (cal_mode_reg != 2'd0)
            begin
                req[i] = (cal_mode_reg == 2'(i + 1)) ? CAL_FORCED : '0;
            end

            if (req[i] == '0)
            begin
                sum = '0;
            end
            else
            begin
                sum = {1'b0, req[i]} + (REQ_W + 1)'(comp_reg[i]);
            end

            scaled = SCALE_W'(adc[i]) * SCALE_W'(MV_MUL);
            if (scaled >= open_thr)
            begin
                cls = ST_OPEN;
            end
            else if (scaled < short_thr)
            begin
                cls = ST_SHORT;
            end
            else
            begin
                cls = ST_NORMAL;
            end

            unique case (op)
                OP_SET_DUTY:
                begin
                    if (sum >= (REQ_W + 1)'(DUTY_PERIOD))
                    begin
                        duty_next[i] = DUTY_MAX;
                    end
                    else
                    begin
                        duty_next[i] = sum[DUTY_W-1:0];
                    end
                    en_next[i] = duty_next[i] > settle_reg;
                end
                OP_SAMPLE:
                begin
                    if (en_reg[i])
                    begin
                        if (is_fault(cls) && deb_reg[i] != '0)
                        begin
                            deb_next[i] = deb_reg[i] - DEB_W'(1);
                        end
                        else
                        begin
                            status_next[i] = cls;
                            deb_next[i]    = debounce_reg;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    deb_next[i] = debounce_reg;
                    if (is_fault(status_reg[i]))
                    begin
                        status_next[i] = ST_INIT;
                    end
                end
                OP_SLEEP:
                begin
                    status_next[i] = ST_INIT;
                end
            endcase
        end

        res_data_next.duty_red    = duty_next[0];
        res_data_next.duty_green  = duty_next[1];
        res_data_next.duty_blue   = duty_next[2];
        res_data_next.trig_red    = duty_next[0][DUTY_W-1:1];
        res_data_next.trig_green  = duty_next[1][DUTY_W-1:1];
        res_data_next.trig_blue   = duty_next[2][DUTY_W-1:1];
        res_data_next.red_state   = status_next[0];
        res_data_next.green_state = status_next[1];
        res_data_next.blue_state  = status_next[2];
        res_data_next.led_fault   = is_fault(status_next[0]) || is_fault(status_next[1])
                                    || is_fault(status_next[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCHAN; i++)
            begin
                duty_reg[i]   <= '0;
                en_reg[i]     <= 1'b0;
                status_reg[i] <= ST_INIT;
                deb_reg[i]    <= DEBOUNCE_RST;
            end
        end
        else if (take)
        begin
            for (int i = 0; i < NCHAN; i++)
            begin
                duty_reg[i]   <= duty_next[i];
                en_reg[i]     <= en_next[i];
                status_reg[i] <= status_next[i];
                deb_reg[i]    <= deb_next[i];
            end
        end
    end

endmodule
